// ----- rtl/brne_pkg.sv -----
package brne_pkg;

    localparam logic [11:0] MAX_VALUE = 12'd3999;
    localparam int unsigned NUM_DIGITS = 4;

    // ASCII codes of the Roman symbols.
    localparam logic [7:0] CHAR_M = 8'h4D;
    localparam logic [7:0] CHAR_D = 8'h44;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_L = 8'h4C;
    localparam logic [7:0] CHAR_X = 8'h58;
    localparam logic [7:0] CHAR_V = 8'h56;
    localparam logic [7:0] CHAR_I = 8'h49;
    localparam logic [7:0] CHAR_NONE = 8'h00;

    typedef logic [3:0] digit_t;
    typedef logic [1:0] digit_idx_t;
    typedef logic [1:0] sym_pos_t;
    typedef logic [2:0] sym_len_t;

    // Role of a symbol within one decimal place.
    typedef enum logic [1:0] {
        SYM_ONE  = 2'd0,
        SYM_FIVE = 2'd1,
        SYM_TEN  = 2'd2
    } sym_code_t;

    // Decimal digits of one number, index 0 holds the thousands.
    typedef struct packed {
        logic                          err;
        digit_t [NUM_DIGITS-1:0]       digits;
    } brne_digits_t;

    // Number of symbols that one decimal digit takes.
    function automatic sym_len_t roman_len(input digit_t d);
        sym_len_t len;
        case (d)
            4'd1, 4'd5:         len = 3'd1;
            4'd2, 4'd4, 4'd6,
            4'd9:               len = 3'd2;
            4'd3, 4'd7:         len = 3'd3;
            4'd8:               len = 3'd4;
            default:            len = 3'd0;
        endcase
        return len;
    endfunction

    // Which symbol of the place stands at a given position of the digit.
    function automatic sym_code_t roman_sym(input digit_t d, input sym_pos_t pos);
        sym_code_t code;
        code = SYM_ONE;
        case (d)
            4'd4:               code = (pos == 2'd0) ? SYM_ONE : SYM_FIVE;
            4'd5, 4'd6, 4'd7,
            4'd8:               code = (pos == 2'd0) ? SYM_FIVE : SYM_ONE;
            4'd9:               code = (pos == 2'd0) ? SYM_ONE : SYM_TEN;
            default:            code = SYM_ONE;
        endcase
        return code;
    endfunction

    // ASCII code for a symbol role at a decimal place (0 ones .. 3 thousands).
    function automatic logic [7:0] roman_char(input logic [1:0] place, input sym_code_t code);
        logic [7:0] ch;
        ch = CHAR_NONE;
        case (place)
            2'd0:
            begin
                case (code)
                    SYM_ONE:  ch = CHAR_I;
                    SYM_FIVE: ch = CHAR_V;
                    default:  ch = CHAR_X;
                endcase
            end
            2'd1:
            begin
                case (code)
                    SYM_ONE:  ch = CHAR_X;
                    SYM_FIVE: ch = CHAR_L;
                    default:  ch = CHAR_C;
                endcase
            end
            2'd2:
            begin
                case (code)
                    SYM_ONE:  ch = CHAR_C;
                    SYM_FIVE: ch = CHAR_D;
                    default:  ch = CHAR_M;
                endcase
            end
            default:
            begin
                ch = (code == SYM_ONE) ? CHAR_M : CHAR_NONE;
            end
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/brne_in_if.sv -----
interface brne_in_if;
    logic        valid;
    logic        ready;
    logic [11:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ----- rtl/brne_out_if.sv -----
interface brne_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol_char;
    logic       last;
    logic       error;

    modport source (output valid, output symbol_char, output last, output error, input ready);
    modport sink   (input valid, input symbol_char, input last, input error, output ready);
endinterface

// ----- rtl/brne_digit_pipe.sv -----
module brne_digit_pipe (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [11:0]           in_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output brne_pkg::brne_digits_t out_digits
);
    import brne_pkg::*;

    // Stage valid bits.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    // Stage payloads.
    logic [11:0]  value1_reg;
    logic         err1_reg, err2_reg, err3_reg;
    digit_t       thou2_reg, thou3_reg, hund3_reg;
    logic [9:0]   rem2_reg;
    logic [6:0]   rem3_reg;
    brne_digits_t dig4_reg;

    logic [9:0]   rem2_next;
    digit_t       thou2_next;
    digit_t       hund3_next;
    logic [6:0]   rem3_next;
    digit_t       tens4_next;
    digit_t       ones4_next;
    logic [11:0]  sub2;
    logic [9:0]   sub3;
    logic [6:0]   sub4;

    // A stage moves when it is empty or its successor moves.
    assign adv4     = !v4_reg || out_ready;
    assign adv3     = !v3_reg || adv4;
    assign adv2     = !v2_reg || adv3;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_comb
    begin
        if (value1_reg >= 12'd3000)
        begin
            thou2_next = 4'd3;
        end
        else if (value1_reg >= 12'd2000)
        begin
            thou2_next = 4'd2;
        end
        else if (value1_reg >= 12'd1000)
        begin
            thou2_next = 4'd1;
        end
        else
        begin
            thou2_next = 4'd0;
        end
        sub2      = value1_reg - 12'(thou2_next * 12'd1000);
        rem2_next = sub2[9:0];
    end

    always_comb
    begin
        hund3_next = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem2_reg >= 10'(k * 100))
            begin
                hund3_next = 4'(k);
            end
        end
        sub3      = rem2_reg - 10'(hund3_next * 10'd100);
        rem3_next = sub3[6:0];
    end

    always_comb
    begin
        tens4_next = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (rem3_reg >= 7'(k * 10))
            begin
                tens4_next = 4'(k);
            end
        end
        sub4       = rem3_reg - 7'(tens4_next * 7'd10);
        ones4_next = sub4[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
            if (adv4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            value1_reg <= in_value;
            err1_reg   <= (in_value == 12'd0) || (in_value > MAX_VALUE);
        end
        if (adv2)
        begin
            thou2_reg <= thou2_next;
            rem2_reg  <= rem2_next;
            err2_reg  <= err1_reg;
        end
        if (adv3)
        begin
            thou3_reg <= thou2_reg;
            hund3_reg <= hund3_next;
            rem3_reg  <= rem3_next;
            err3_reg  <= err2_reg;
        end
        if (adv4)
        begin
            dig4_reg.err       <= err3_reg;
            dig4_reg.digits[0] <= thou3_reg;
            dig4_reg.digits[1] <= hund3_reg;
            dig4_reg.digits[2] <= tens4_next;
            dig4_reg.digits[3] <= ones4_next;
        end
    end

    assign out_valid  = v4_reg;
    assign out_digits = dig4_reg;

endmodule

// ----- rtl/binary_to_roman_numeral_emitter.sv -----
// Path: an accepted value passes through four digit-pipeline stages, the first loaded at
// the accepting edge, then through the output register, before its first character shows.
// Throughput: one character per cycle while the output is not stalled; a numeral has 1 to 15
// characters, and the single-character output register sends them out one at a time.
// Reset: rst_n is asynchronous and active low; it empties every stage and the output.
module binary_to_roman_numeral_emitter (
    input  logic       clk,
    input  logic       rst_n,
    brne_in_if.sink    in_ch,
    brne_out_if.source out_ch
);
    import brne_pkg::*;

    // The digit pipeline splits the number into thousands, hundreds, tens and ones, the
    // tens and ones together in its last stage, and flags values outside 1 to 3999.
    logic         dig_valid;
    logic         dig_pop;
    brne_digits_t dig;

    brne_digit_pipe u_digit_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_value   (in_ch.value),
        .out_valid  (dig_valid),
        .out_ready  (dig_pop),
        .out_digits (dig)
    );

    // The emitter walks the digits of the number held at the pipeline end. idx_reg
    // points at the first place not yet finished and pos_reg at the symbol within
    // that place's digit. Places whose digit is zero are skipped combinationally.
    digit_idx_t idx_reg, idx_next;
    sym_pos_t   pos_reg, pos_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       error_reg;

    digit_idx_t cur;
    digit_t     cur_digit;
    sym_len_t   cur_len;
    logic       later_nonzero;
    logic       end_of_digit;
    logic       last_char;
    logic       emit;
    logic [7:0] char_next;

    // Find the first nonzero digit at or after idx_reg, and whether any nonzero
    // digit remains after it.
    always_comb
    begin
        cur = 2'd3;
        for (int j = NUM_DIGITS - 1; j >= 0; j--)
        begin
            if ((2'(j) >= idx_reg) && (dig.digits[j] != 4'd0))
            begin
                cur = 2'(j);
            end
        end
        later_nonzero = 1'b0;
        for (int j = 0; j < NUM_DIGITS; j++)
        begin
            if ((2'(j) > cur) && (dig.digits[j] != 4'd0))
            begin
                later_nonzero = 1'b1;
            end
        end
    end

    assign cur_digit    = dig.digits[cur];
    assign cur_len      = roman_len(cur_digit);
    assign end_of_digit = ({1'b0, pos_reg} + 3'd1) >= cur_len;
    assign last_char    = dig.err || (end_of_digit && !later_nonzero);
    assign char_next    = dig.err ? CHAR_NONE :
                          roman_char(2'(3 - cur), roman_sym(cur_digit, pos_reg));

    // A character goes out when digits are waiting and the output is free or being drained.
    assign emit    = dig_valid && (!out_valid_reg || out_ch.ready);
    assign dig_pop = emit && last_char;

    always_comb
    begin
        idx_next = idx_reg;
        pos_next = pos_reg;
        if (emit)
        begin
            if (last_char)
            begin
                idx_next = 2'd0;
                pos_next = 2'd0;
            end
            else if (end_of_digit)
            begin
                idx_next = cur + 2'd1;
                pos_next = 2'd0;
            end
            else
            begin
                idx_next = cur;
                pos_next = pos_reg + 2'd1;
            end
        end
        out_valid_next = emit || (out_valid_reg && !out_ch.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            pos_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            char_reg  <= char_next;
            last_reg  <= last_char;
            error_reg <= dig.err;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.symbol_char = char_reg;
    assign out_ch.last        = last_reg;
    assign out_ch.error       = error_reg;

`ifndef NO_ASSERTIONS
    // An error transaction is always a single, final, empty character.
    a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.error |-> out_ch.last && (out_ch.symbol_char == CHAR_NONE))
        else $error("error result not a lone final null character");

    // A regular character is always a real symbol.
    a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.error |-> (out_ch.symbol_char != CHAR_NONE))
        else $error("null character emitted without error");

    // The symbol position never runs past the end of the current digit.
    a_pos_in_digit: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && !dig.err |-> ({1'b0, pos_reg} < cur_len))
        else $error("symbol position beyond digit length");

    // Finishing a number returns the walk to its start.
    a_walk_restart: assert property (@(posedge clk) disable iff (!rst_n)
        dig_pop |=> (idx_reg == 2'd0) && (pos_reg == 2'd0))
        else $error("emitter walk not restarted after a number");

    // A stalled output holds its character.
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(char_reg))
        else $error("output changed while stalled");
`endif

endmodule
